/* hw/rtl/btin_pkg.sv */
// Shared types and constants of the bilinear table interpolator.
package btin_pkg;

    // Function codes of an input beat.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ORIGIN_X       = 2'd0,
        CFG_ORIGIN_Y       = 2'd1,
        CFG_INVERSE_STEP_X = 2'd2,
        CFG_INVERSE_STEP_Y = 2'd3
    } t_cfg_idx;

    // Fixed-point constants.
    localparam logic [16:0] FRAC_ONE   = 17'd65536;
    localparam logic signed [51:0] ROUND_HALF = 52'sd2147483648;

    // Input beat.
    typedef struct packed {
        logic               func;
        logic [5:0]         write_col;
        logic [5:0]         write_row;
        logic signed [15:0] write_value;
        logic signed [31:0] query_x_a;
        logic signed [31:0] query_x_b;
        logic signed [31:0] query_y;
    } t_in;

    // Output beat.
    typedef struct packed {
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
    } t_out;

    // Per-stage load enables handed to the axis mappers and lanes.
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
        logic ld7;
    } t_adv;

endpackage

/* hw/rtl/btin_axis_map.sv */
// Three-stage mapper from a Q16.16 coordinate to a grid index and fraction.
module btin_axis_map #(
    parameter int N = 64
) (
    input  logic                 i_clk,
    input  btin_pkg::t_adv       i_adv,
    input  logic signed [31:0]   i_coord,
    input  logic [31:0]          i_origin,
    input  logic [31:0]          i_inv,
    output logic [$clog2(N)-1:0] o_idx,
    output logic [15:0]          o_frac
);

    localparam int IW = $clog2(N);
    localparam logic [31:0] LAST = 32'(N - 1);

    logic signed [33:0] n_diff;
    logic [31:0]        r_d;
    logic [63:0]        r_p;
    logic [IW-1:0]      r_idx;
    logic [15:0]        r_frac;

    // Clamp below at zero and subtract the origin exactly.
    always_comb begin
        if (i_coord < 0) begin
            n_diff = 34'sd0 - 34'(signed'(i_origin));
        end else begin
            n_diff = 34'(i_coord) - 34'(signed'(i_origin));
        end
    end

    // Positive offset, scaled product, then index and fraction split.
    always_ff @(posedge i_clk) begin
        if (i_adv.ld2) begin
            r_d <= (n_diff > 0) ? n_diff[31:0] : 32'd0;
        end
        if (i_adv.ld3) begin
            r_p <= 64'(r_d) * 64'(i_inv);
        end
        if (i_adv.ld4) begin
            if (r_p[63:32] >= LAST) begin
                r_idx  <= LAST[IW-1:0];
                r_frac <= 16'd0;
            end else begin
                r_idx  <= r_p[IW+31:32];
                r_frac <= r_p[31:16];
            end
        end
    end

    assign o_idx  = r_idx;
    assign o_frac = r_frac;

endmodule

/* hw/rtl/btin_lane.sv */
// One interpolation lane: neighbor addressing, table copies and weighted blend.
module btin_lane #(
    parameter int COLS = 64,
    parameter int ROWS = 64
) (
    input  logic                              i_clk,
    input  btin_pkg::t_adv                    i_adv,
    input  logic [$clog2(COLS)-1:0]           i_xi,
    input  logic [15:0]                       i_tx,
    input  logic [$clog2(ROWS)-1:0]           i_yi,
    input  logic [15:0]                       i_ty,
    input  logic                              i_wr_en,
    input  logic [$clog2(ROWS*COLS)-1:0]      i_wr_addr,
    input  logic signed [15:0]                i_wr_data,
    output logic signed [15:0]                o_value
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(COLS);
    localparam int YW    = $clog2(ROWS);

    logic [XW-1:0]      n_xi1;
    logic [YW-1:0]      n_yi1;
    logic [AW-1:0]      n_row0;
    logic [AW-1:0]      n_row1;
    logic [16:0]        n_ux;
    logic [16:0]        n_uy;
    logic [AW-1:0]      r_a00, r_a01, r_a10, r_a11;
    logic [32:0]        r_w00, r_w01, r_w10, r_w11;
    logic [32:0]        r_v00, r_v01, r_v10, r_v11;
    logic signed [15:0] r_c00, r_c01, r_c10, r_c11;
    logic signed [49:0] r_p00, r_p01, r_p10, r_p11;
    logic signed [51:0] n_sum;
    logic signed [15:0] r_mem0 [DEPTH];
    logic signed [15:0] r_mem1 [DEPTH];

    // Neighbor indexes clamp at the last column and row.
    always_comb begin
        n_xi1  = (32'(i_xi) < 32'(COLS - 1)) ? i_xi + XW'(1) : i_xi;
        n_yi1  = (32'(i_yi) < 32'(ROWS - 1)) ? i_yi + YW'(1) : i_yi;
        n_row0 = AW'(AW'(i_yi) * AW'(COLS));
        n_row1 = AW'(AW'(n_yi1) * AW'(COLS));
        n_ux   = btin_pkg::FRAC_ONE - 17'(i_tx);
        n_uy   = btin_pkg::FRAC_ONE - 17'(i_ty);
    end

    // Addresses of the four neighbors and the four blend weights.
    always_ff @(posedge i_clk) begin
        if (i_adv.ld5) begin
            r_a00 <= n_row0 + AW'(i_xi);
            r_a01 <= n_row0 + AW'(n_xi1);
            r_a10 <= n_row1 + AW'(i_xi);
            r_a11 <= n_row1 + AW'(n_xi1);
            r_w00 <= 33'(34'(n_ux) * 34'(n_uy));
            r_w01 <= 33'(34'(i_tx) * 34'(n_uy));
            r_w10 <= 33'(34'(n_ux) * 34'(i_ty));
            r_w11 <= 33'(34'(i_tx) * 34'(i_ty));
        end
    end

    // Two table copies, one per neighbor row, each read at two columns.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem0[i_wr_addr] <= i_wr_data;
            r_mem1[i_wr_addr] <= i_wr_data;
        end
        if (i_adv.ld6) begin
            r_c00 <= r_mem0[r_a00];
            r_c01 <= r_mem0[r_a01];
            r_c10 <= r_mem1[r_a10];
            r_c11 <= r_mem1[r_a11];
            r_v00 <= r_w00;
            r_v01 <= r_w01;
            r_v10 <= r_w10;
            r_v11 <= r_w11;
        end
    end

    // Weighted neighbors.
    always_ff @(posedge i_clk) begin
        if (i_adv.ld7) begin
            r_p00 <= 50'($signed({1'b0, r_v00})) * 50'(r_c00);
            r_p01 <= 50'($signed({1'b0, r_v01})) * 50'(r_c01);
            r_p10 <= 50'($signed({1'b0, r_v10})) * 50'(r_c10);
            r_p11 <= 50'($signed({1'b0, r_v11})) * 50'(r_c11);
        end
    end

    // Sum and round to nearest, ties upward; weights sum to one in Q0.32.
    always_comb begin
        n_sum = 52'(r_p00) + 52'(r_p01) + 52'(r_p10) + 52'(r_p11)
              + btin_pkg::ROUND_HALF;
    end

    assign o_value = n_sum[47:32];

endmodule

/* hw/rtl/bilinear_table_interpolator_unit.sv */
// Top level of the bilinear table interpolator: handshakes, configuration and lanes.
//
// The block takes one beat per clock cycle, writes and queries alike,
// unless an output stall fills the pipeline, and returns a query's two
// interpolated values as one beat; writes produce no output beat. Queries
// pass through a three-stage coordinate mapper (clamp and offset, 32x32
// scale, index split), a neighbor-addressing and weight stage, a table read,
// a weighting multiply and a rounding sum that feeds the output register.
// Each lane holds two copies of the ROWS x COLS sample table, one per
// neighbor row, each read at two columns per cycle, so all eight neighbors
// of both lanes are fetched together. A table write takes effect at the
// read stage, so every query sees exactly the writes accepted before it.
// Entries must be written before a query reads them. Stages hold their beat
// under output stall and empty stages keep taking input.
module bilinear_table_interpolator_unit #(
    parameter int COLS = 64,
    parameter int ROWS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  btin_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output btin_pkg::t_out    o_out_data,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam int AW = $clog2(ROWS * COLS);
    localparam int XW = $clog2(COLS);
    localparam int YW = $clog2(ROWS);

    logic [8:1]         n_ld;
    logic [8:1]         r_vld;
    btin_pkg::t_adv     n_adv;
    logic [31:0]        r_origin_x, r_origin_y, r_inv_x, r_inv_y;
    btin_pkg::t_in      r_s1;
    logic               r_s2_func, r_s3_func, r_s4_func, r_s5_func;
    logic [5:0]         r_s2_col, r_s3_col, r_s4_col, r_s5_col;
    logic [5:0]         r_s2_row, r_s3_row, r_s4_row, r_s5_row;
    logic signed [15:0] r_s2_val, r_s3_val, r_s4_val, r_s5_val;
    logic               n_wr_en;
    logic [AW-1:0]      n_wr_addr;
    logic [YW-1:0]      w_yi;
    logic [15:0]        w_ty;
    logic [XW-1:0]      w_xi_a, w_xi_b;
    logic [15:0]        w_tx_a, w_tx_b;
    logic signed [15:0] w_val_a, w_val_b;
    btin_pkg::t_out     r_out;

    // A stage loads when it is empty or its successor loads.
    always_comb begin
        n_ld[8] = !r_vld[8] || !i_out_stall;
        for (int k = 7; k >= 1; k--) begin
            n_ld[k] = !r_vld[k] || n_ld[k+1];
        end
        n_adv.ld2 = n_ld[2];
        n_adv.ld3 = n_ld[3];
        n_adv.ld4 = n_ld[4];
        n_adv.ld5 = n_ld[5];
        n_adv.ld6 = n_ld[6];
        n_adv.ld7 = n_ld[7];
    end

    // Stage valids and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_origin_x <= 32'd0;
            r_origin_y <= 32'd0;
            r_inv_x    <= 32'd65536;
            r_inv_y    <= 32'd65536;
        end else begin
            if (n_ld[1]) r_vld[1] <= i_in_valid;
            for (int k = 2; k <= 5; k++) begin
                if (n_ld[k]) r_vld[k] <= r_vld[k-1];
            end
            if (n_ld[6]) r_vld[6] <= r_vld[5] && (r_s5_func == btin_pkg::FUNC_QUERY);
            if (n_ld[7]) r_vld[7] <= r_vld[6];
            if (n_ld[8]) r_vld[8] <= r_vld[7];
            if (i_cfg_we) begin
                unique case (btin_pkg::t_cfg_idx'(i_cfg_index))
                    btin_pkg::CFG_ORIGIN_X:       r_origin_x <= i_cfg_data;
                    btin_pkg::CFG_ORIGIN_Y:       r_origin_y <= i_cfg_data;
                    btin_pkg::CFG_INVERSE_STEP_X: r_inv_x    <= i_cfg_data;
                    btin_pkg::CFG_INVERSE_STEP_Y: r_inv_y    <= i_cfg_data;
                endcase
            end
        end
    end

    // Input register and the write fields that travel to the read stage.
    always_ff @(posedge i_clk) begin
        if (n_ld[1]) r_s1 <= i_in_data;
        if (n_ld[2]) begin
            r_s2_func <= r_s1.func;
            r_s2_col  <= r_s1.write_col;
            r_s2_row  <= r_s1.write_row;
            r_s2_val  <= r_s1.write_value;
        end
        if (n_ld[3]) begin
            r_s3_func <= r_s2_func;
            r_s3_col  <= r_s2_col;
            r_s3_row  <= r_s2_row;
            r_s3_val  <= r_s2_val;
        end
        if (n_ld[4]) begin
            r_s4_func <= r_s3_func;
            r_s4_col  <= r_s3_col;
            r_s4_row  <= r_s3_row;
            r_s4_val  <= r_s3_val;
        end
        if (n_ld[5]) begin
            r_s5_func <= r_s4_func;
            r_s5_col  <= r_s4_col;
            r_s5_row  <= r_s4_row;
            r_s5_val  <= r_s4_val;
        end
    end

    // Table write as the write beat enters the read stage; outside writes drop.
    always_comb begin
        n_wr_en = r_vld[5] && n_ld[6] && (r_s5_func == btin_pkg::FUNC_WRITE)
               && (32'(r_s5_col) < 32'(COLS)) && (32'(r_s5_row) < 32'(ROWS));
        n_wr_addr = AW'(AW'(r_s5_row) * AW'(COLS)) + AW'(r_s5_col);
    end

    // Row mapping is shared; each lane maps its own column.
    btin_axis_map #(.N(ROWS)) u_map_y (
        .i_clk(i_clk), .i_adv(n_adv), .i_coord(r_s1.query_y),
        .i_origin(r_origin_y), .i_inv(r_inv_y), .o_idx(w_yi), .o_frac(w_ty)
    );

    btin_axis_map #(.N(COLS)) u_map_xa (
        .i_clk(i_clk), .i_adv(n_adv), .i_coord(r_s1.query_x_a),
        .i_origin(r_origin_x), .i_inv(r_inv_x), .o_idx(w_xi_a), .o_frac(w_tx_a)
    );

    btin_axis_map #(.N(COLS)) u_map_xb (
        .i_clk(i_clk), .i_adv(n_adv), .i_coord(r_s1.query_x_b),
        .i_origin(r_origin_x), .i_inv(r_inv_x), .o_idx(w_xi_b), .o_frac(w_tx_b)
    );

    btin_lane #(.COLS(COLS), .ROWS(ROWS)) u_lane_a (
        .i_clk(i_clk), .i_adv(n_adv), .i_xi(w_xi_a), .i_tx(w_tx_a),
        .i_yi(w_yi), .i_ty(w_ty), .i_wr_en(n_wr_en), .i_wr_addr(n_wr_addr),
        .i_wr_data(r_s5_val), .o_value(w_val_a)
    );

    btin_lane #(.COLS(COLS), .ROWS(ROWS)) u_lane_b (
        .i_clk(i_clk), .i_adv(n_adv), .i_xi(w_xi_b), .i_tx(w_tx_b),
        .i_yi(w_yi), .i_ty(w_ty), .i_wr_en(n_wr_en), .i_wr_addr(n_wr_addr),
        .i_wr_data(r_s5_val), .o_value(w_val_b)
    );

    // Output register merges both lanes into one beat.
    always_ff @(posedge i_clk) begin
        if (n_ld[8]) begin
            r_out.value_a <= w_val_a;
            r_out.value_b <= w_val_b;
        end
    end

    assign o_in_stall  = !n_ld[1];
    assign o_out_valid = r_vld[8];
    assign o_out_data  = r_out;

endmodule

/* bench/tb_bilinear_table_interpolator_unit.sv */
// Testbench for the bilinear table interpolator: self-checking random and directed run.
module tb_bilinear_table_interpolator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Predicts interpolated outputs and checks result beats in order.
    class interp_scoreboard;
        logic signed [15:0] grid [64*64];
        logic [31:0] org_x, org_y, inv_x, inv_y;
        btin_pkg::t_out pending [$];
        int errors;

        function new();
            org_x = 32'd0; org_y = 32'd0; inv_x = 32'd65536; inv_y = 32'd65536;
            errors = 0;
            foreach (grid[i]) grid[i] = '0;
        endfunction

        function void set_reg(btin_pkg::t_cfg_idx idx, logic [31:0] v);
            case (idx)
                btin_pkg::CFG_ORIGIN_X:       org_x = v;
                btin_pkg::CFG_ORIGIN_Y:       org_y = v;
                btin_pkg::CFG_INVERSE_STEP_X: inv_x = v;
                default:                      inv_y = v;
            endcase
        endfunction

        // Coordinate to grid index and 16-bit fraction.
        function void map_coord(logic signed [31:0] c, logic [31:0] org, logic [31:0] inv,
                                output int unsigned idx, output int unsigned frac);
            longint signed cc, d;
            logic [63:0] p;
            cc = longint'(c);
            if (cc < 0) cc = 0;
            d = cc - longint'($signed(org));
            p = (d <= 0) ? 64'd0 : 64'(d) * 64'(inv);
            if (p[63:32] >= 63) begin
                idx = 63; frac = 0;
            end else begin
                idx = p[63:32]; frac = 32'(p[31:16]);
            end
        endfunction

        function logic signed [15:0] mix(int unsigned xi, int unsigned tx,
                                          int unsigned yi, int unsigned ty);
            int unsigned x1, y1;
            longint signed ux, uy, s;
            x1 = (xi < 63) ? xi + 1 : 63;
            y1 = (yi < 63) ? yi + 1 : 63;
            ux = 65536 - longint'(tx);
            uy = 65536 - longint'(ty);
            s = ux * uy * grid[yi*64+xi] + longint'(tx) * uy * grid[yi*64+x1]
              + ux * longint'(ty) * grid[y1*64+xi]
              + longint'(tx) * longint'(ty) * grid[y1*64+x1];
            s = s + 64'sh0000_0000_8000_0000;
            return 16'(s >>> 32);
        endfunction

        function void note_input(btin_pkg::t_in b);
            int unsigned yi, ty, xi, tx;
            btin_pkg::t_out r;
            if (b.func == btin_pkg::FUNC_WRITE) begin
                grid[b.write_row*64 + b.write_col] = b.write_value;
                return;
            end
            map_coord(b.query_y, org_y, inv_y, yi, ty);
            map_coord(b.query_x_a, org_x, inv_x, xi, tx);
            r.value_a = mix(xi, tx, yi, ty);
            map_coord(b.query_x_b, org_x, inv_x, xi, tx);
            r.value_b = mix(xi, tx, yi, ty);
            pending.push_back(r);
        endfunction

        function void check_result(btin_pkg::t_out got);
            btin_pkg::t_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.value_a !== e.value_a) begin
                $display("%0t: value_a expected %0d actual %0d", $time, e.value_a, got.value_a);
                errors++;
            end
            if (got.value_b !== e.value_b) begin
                $display("%0t: value_b expected %0d actual %0d", $time, e.value_b, got.value_b);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, i_out_stall = 0, i_cfg_we = 0;
    logic o_in_stall, o_out_valid;
    btin_pkg::t_in i_in_data = '0;
    btin_pkg::t_out o_out_data;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    interp_scoreboard sb = new();
    bit stall_random = 1;
    bit written [64*64];
    int sent = 0;

    bilinear_table_interpolator_unit uut (.*);

    always #2 i_clk = ~i_clk;

    // Result beats are checked at the rising edge.
    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);

    // Receiver stall pattern: alternating calm and busy windows.
    always @(negedge i_clk) begin
        int phase;
        phase = int'(($time / 400) % 3);
        if (!stall_random || phase == 0) i_out_stall <= 0;
        else if (phase == 1) i_out_stall <= ($urandom_range(0, 3) == 0);
        else i_out_stall <= ($urandom_range(0, 1) == 0);
    end

    // Sends one beat and waits until it is accepted.
    task automatic send_beat(btin_pkg::t_in b);
        i_in_data <= b;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(b);
        sent++;
        if (b.func == btin_pkg::FUNC_WRITE) written[b.write_row*64 + b.write_col] = 1;
        @(negedge i_clk);
    endtask

    task automatic gap();
        i_in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task automatic write_entry(int r, int c, logic signed [15:0] v);
        btin_pkg::t_in b;
        b = '0;
        b.func = btin_pkg::FUNC_WRITE; b.write_row = 6'(r); b.write_col = 6'(c);
        b.write_value = v;
        send_beat(b);
    endtask

    // Writes any of the four neighbors of a grid point that is still unwritten.
    task automatic cover_cells(int unsigned xi, int unsigned yi);
        int unsigned x1, y1;
        x1 = (xi < 63) ? xi + 1 : 63;
        y1 = (yi < 63) ? yi + 1 : 63;
        if (!written[yi*64+xi]) write_entry(int'(yi), int'(xi), 16'($urandom));
        if (!written[yi*64+x1]) write_entry(int'(yi), int'(x1), 16'($urandom));
        if (!written[y1*64+xi]) write_entry(int'(y1), int'(xi), 16'($urandom));
        if (!written[y1*64+x1]) write_entry(int'(y1), int'(x1), 16'($urandom));
    endtask

    task automatic query(logic [31:0] xa, logic [31:0] xb, logic [31:0] y);
        btin_pkg::t_in b;
        int unsigned yi, ty, xi, tx;
        sb.map_coord(y, sb.org_y, sb.inv_y, yi, ty);
        sb.map_coord(xa, sb.org_x, sb.inv_x, xi, tx);
        cover_cells(xi, yi);
        sb.map_coord(xb, sb.org_x, sb.inv_x, xi, tx);
        cover_cells(xi, yi);
        b = btin_pkg::t_in'($bits(btin_pkg::t_in)'({$urandom, $urandom, $urandom, $urandom}));
        b.func = btin_pkg::FUNC_QUERY; b.query_x_a = xa; b.query_x_b = xb; b.query_y = y;
        send_beat(b);
    endtask

    // Drains outstanding results, then writes a register while idle.
    task automatic set_reg(btin_pkg::t_cfg_idx idx, logic [31:0] v);
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, v);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return $urandom_range(0, 64 * 65536);
        endcase
    endfunction

    initial begin
        int burst;
        int base;
        logic [31:0] ox, oy, sx, sy;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Extreme sample values at and beside two corners; other entries are written on demand.
        stall_random = 0;
        write_entry(0, 0, 16'h7fff);
        write_entry(0, 1, 16'h8000);
        write_entry(63, 63, 16'h8000);
        stall_random = 1;

        // Directed corners, clamps, saturation and half-way points.
        query(32'h0, 32'h8000, 32'h0);
        query(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        query(32'h7fff_ffff, 32'h003f_0000, 32'h003e_ffff);
        query(32'h0000_8000, 32'h0000_7fff, 32'h0000_8000);
        query(32'h003e_8000, 32'h0001_0000, 32'h8000_0000);
        write_entry(63, 0, 16'h7fff);
        query(32'h0, 32'h0040_0000, 32'h003f_0000);

        // Register settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin ox = 0; oy = 0; sx = 32'd65536; sy = 32'd65536; end
                1: begin ox = 32'h8000_0000; oy = 32'h7fff_ffff; sx = 0; sy = 32'hffff_ffff; end
                2: begin ox = 32'h7fff_ffff; oy = 32'h8000_0000; sx = 32'hffff_ffff; sy = 0; end
                3: begin ox = 32'h0001_0000; oy = 32'hffff_0000; sx = 32'd32768;
                         sy = 32'd131072; end
                4: begin ox = $urandom; oy = $urandom_range(0, 32'h10_0000);
                         sx = $urandom_range(1, 32'h4_0000); sy = $urandom; end
                default: begin ox = 0; oy = 0; sx = 32'd65536; sy = 32'd65536; end
            endcase
            set_reg(btin_pkg::CFG_ORIGIN_X, ox);
            set_reg(btin_pkg::CFG_ORIGIN_Y, oy);
            set_reg(btin_pkg::CFG_INVERSE_STEP_X, sx);
            set_reg(btin_pkg::CFG_INVERSE_STEP_Y, sy);
            base = sent;
            while (sent - base < 95) begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst; k++) begin
                    if ($urandom_range(0, 4) == 0)
                        write_entry($urandom_range(0, 63), $urandom_range(0, 63),
                                    16'($urandom));
                    else
                        query(rand_coord(), rand_coord(), rand_coord());
                end
                if ($urandom_range(0, 2) != 0) gap();
            end
        end

        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog.
    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/btin_pkg.sv
hw/rtl/btin_axis_map.sv
hw/rtl/btin_lane.sv
hw/rtl/bilinear_table_interpolator_unit.sv
bench/tb_bilinear_table_interpolator_unit.sv
